>>> design/tbss_pkg.sv
// Shared types and constants of the triple-redundant byte store scrubber.
package tbss_pkg;

  localparam int FUNC_W = 3;
  localparam int ADDR_W = 10;
  localparam int BYTE_W = 8;
  localparam int SEL_W  = 2;
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 32;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 120;
  localparam int PADDR_W = 3;

  localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_COMMIT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SCRUB  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  localparam logic [SEL_W-1:0] SEL_LIVE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_B    = 2'd1;
  localparam logic [SEL_W-1:0] SEL_C    = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_PROTECTED = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  scrub_runs_total;
    logic [CNT_W-1:0]  uncorrectable_total;
    logic [CNT_W-1:0]  corrected_total;
    logic [LEN_W-1:0]  divergent_count;
    logic [BYTE_W-1:0] rdata;
  } result_t;

endpackage

>>> design/tmr_byte_store_scrubber.sv
// Triple-redundant byte store with commit and 2-of-3 majority scrub.
//
// The block keeps three copies of a STORE_BYTES byte store (live, shadow B,
// shadow C), each in its own single-port-write, single-port-read memory with
// a registered read. One item moves through s_tvalid/s_tready and gives
// exactly one result item on m_tvalid/m_tready; the block takes one item at a
// time and holds s_tready low from acceptance until its result is taken.
// Path from acceptance to the result: a write, a clear of the statistics or
// an unused function code shows its result on the next cycle; a read passes
// through ST_ACCESS, where the registered memory read is taken, before ST_RESP.
// Commit and scrub walk the protected length N (protected_bytes, limited to
// STORE_BYTES) one byte per cycle, reading all three copies at one address
// while the voter repairs the byte read in the cycle before. After reset a
// clearing pass zeroes the three copies, one address per cycle, with s_tready
// low; configuration writes are taken meanwhile. The scrub order is: live
// equals B repairs C, live equals C repairs B, B equals C repairs live; with
// three distinct bytes, B goes into live and C. The running totals wrap at 32
// bits.
// Register protected_bytes lies at byte address 0 of the APB port.
module tmr_byte_store_scrubber import tbss_pkg::*; #(
  parameter int STORE_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  // s_tdata: func[2:0], addr[12:3], wdata[20:13], copy_select[22:21], zero[23]
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,
  // m_tdata: rdata[7:0], divergent_count[18:8], corrected_total[50:19],
  //          uncorrectable_total[82:51], scrub_runs_total[114:83], zero[119:115]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(STORE_BYTES - 1);

  state_t state, state_next;

  // Three copies of the store
  logic [BYTE_W-1:0] live_mem [STORE_BYTES];
  logic [BYTE_W-1:0] b_mem    [STORE_BYTES];
  logic [BYTE_W-1:0] c_mem    [STORE_BYTES];
  logic [BYTE_W-1:0] live_rd, b_rd, c_rd;
  logic [BYTE_W-1:0] live_wd, b_wd, c_wd;
  logic              live_we, b_we, c_we;
  logic [AW-1:0]     rd_addr, wr_addr;

  logic [AW-1:0]     clr_idx;
  logic [LEN_W-1:0]  protected_bytes, cover_len;
  logic [LEN_W-1:0]  issue_idx, pend_idx, div_cnt;
  logic              pend, is_scrub;
  logic [SEL_W-1:0]  acc_sel;
  logic              acc_ok;
  logic [CNT_W-1:0]  corrected_count, uncorrectable_count, scrub_count;
  logic [BYTE_W-1:0] out_rdata;
  logic [LEN_W-1:0]  out_div;
  result_t           result;

  // Input item fields
  logic [FUNC_W-1:0] in_func;
  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_wdata;
  logic [SEL_W-1:0]  in_sel;
  logic              in_accept, in_ok, cfg_write;
  logic              issue_more, walk_done;
  logic              eq_ab, eq_ac, eq_bc, all_eq, diverged, corr_inc, unc_inc;

  assign in_func   = s_tdata[2:0];
  assign in_addr   = s_tdata[12:3];
  assign in_wdata  = s_tdata[20:13];
  assign in_sel    = s_tdata[22:21];
  assign in_accept = s_tvalid & s_tready;

  // A read or write touches a copy only for a real copy and an address in the store
  assign in_ok = ((in_sel == SEL_LIVE) || (in_sel == SEL_B) || (in_sel == SEL_C)) &&
                 (32'(in_addr) < 32'(STORE_BYTES));

  // Commit and scrub cover at most the whole store
  assign cover_len = (32'(protected_bytes) > 32'(STORE_BYTES)) ? LEN_W'(STORE_BYTES)
                                                               : protected_bytes;

  assign issue_more = (issue_idx != cover_len);
  assign walk_done  = !issue_more && !pend;

  // Shared voter: compares the three bytes of the pending address
  assign eq_ab    = (live_rd == b_rd);
  assign eq_ac    = (live_rd == c_rd);
  assign eq_bc    = (b_rd == c_rd);
  assign all_eq   = eq_ab && eq_ac;
  assign diverged = (state == ST_WALK) && pend && is_scrub && !all_eq;
  assign corr_inc = diverged && (eq_ab || eq_ac || eq_bc);
  assign unc_inc  = diverged && !(eq_ab || eq_ac || eq_bc);

  assign cfg_write = psel && penable && pwrite && pready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_ENTRY) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_func)
            FN_READ:   state_next = ST_ACCESS;
            FN_COMMIT: state_next = ST_WALK;
            FN_SCRUB:  state_next = ST_WALK;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_ACCESS: state_next = ST_RESP;
      ST_WALK: begin
        if (walk_done) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Handshake and memory port control
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_RESP);
    rd_addr  = (state == ST_WALK) ? AW'(issue_idx) : AW'(in_addr);
    wr_addr  = AW'(in_addr);
    live_we  = 1'b0;
    b_we     = 1'b0;
    c_we     = 1'b0;
    live_wd  = in_wdata;
    b_wd     = in_wdata;
    c_wd     = in_wdata;
    case (state)
      ST_CLEAR: begin
        wr_addr = clr_idx;
        live_we = 1'b1;
        b_we    = 1'b1;
        c_we    = 1'b1;
        live_wd = '0;
        b_wd    = '0;
        c_wd    = '0;
      end
      ST_IDLE: begin
        if (in_accept && (in_func == FN_WRITE) && in_ok) begin
          live_we = (in_sel == SEL_LIVE);
          b_we    = (in_sel == SEL_B);
          c_we    = (in_sel == SEL_C);
        end
      end
      ST_WALK: begin
        wr_addr = AW'(pend_idx);
        b_wd    = live_rd;
        c_wd    = live_rd;
        live_wd = b_rd;
        if (pend && !is_scrub) begin
          // commit: copy live into both shadows
          b_we = 1'b1;
          c_we = 1'b1;
        end else if (diverged) begin
          if (eq_ab) begin
            c_we = 1'b1;
          end else if (eq_ac) begin
            b_we = 1'b1;
          end else if (eq_bc) begin
            live_we = 1'b1;
          end else begin
            // three distinct bytes: shadow B wins
            live_we = 1'b1;
            c_we    = 1'b1;
            c_wd    = b_rd;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (live_we) live_mem[wr_addr] <= live_wd;
    live_rd <= live_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[wr_addr] <= b_wd;
    b_rd <= b_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[wr_addr] <= c_wd;
    c_rd <= c_mem[rd_addr];
  end

  // Control state, configuration and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_CLEAR;
      clr_idx             <= '0;
      pend                <= 1'b0;
      protected_bytes     <= '0;
      corrected_count     <= '0;
      uncorrectable_count <= '0;
      scrub_count         <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (cfg_write && (paddr[2] == REG_PROTECTED)) protected_bytes <= pwdata[LEN_W-1:0];
      if (in_accept) pend <= 1'b0;
      if (in_accept && (in_func == FN_CLEAR)) begin
        corrected_count     <= '0;
        uncorrectable_count <= '0;
        scrub_count         <= '0;
      end
      if (state == ST_WALK) begin
        pend <= issue_more;
        if (corr_inc) corrected_count <= corrected_count + 1'b1;
        if (unc_inc) uncorrectable_count <= uncorrectable_count + 1'b1;
        if (walk_done && is_scrub) scrub_count <= scrub_count + 1'b1;
      end
    end
  end

  // Item context, walk position and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          is_scrub  <= (in_func == FN_SCRUB);
          acc_sel   <= in_sel;
          acc_ok    <= in_ok;
          issue_idx <= '0;
          div_cnt   <= '0;
          out_rdata <= '0;
          out_div   <= '0;
        end
      end
      ST_ACCESS: begin
        if (acc_ok) begin
          case (acc_sel)
            SEL_LIVE: out_rdata <= live_rd;
            SEL_B:    out_rdata <= b_rd;
            SEL_C:    out_rdata <= c_rd;
            default:  out_rdata <= '0;
          endcase
        end
      end
      ST_WALK: begin
        if (issue_more) begin
          issue_idx <= issue_idx + 1'b1;
          pend_idx  <= issue_idx;
        end
        if (diverged) div_cnt <= div_cnt + 1'b1;
        if (walk_done && is_scrub) out_div <= div_cnt;
      end
      default: begin
      end
    endcase
  end

  // Totals are stable while a result waits, so they are shown directly
  always_comb begin
    result.rdata               = out_rdata;
    result.divergent_count     = out_div;
    result.corrected_total     = corrected_count;
    result.uncorrectable_total = uncorrectable_count;
    result.scrub_runs_total    = scrub_count;
  end

  assign m_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, result};

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROTECTED) ? 32'(protected_bytes) : 32'd0;

endmodule

>>> design/tbss_chk.sv
// Port-level checker for the byte store scrubber, bound to the top level.
module tbss_chk import tbss_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  // One item at a time: never ready while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("ready while a result is pending");

  // Reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("ready right after reset");

  // A write item is answered on the next cycle
  a_write_resp: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[2:0] == FN_WRITE) |=> m_tvalid)
    else $error("write item gave no result");

  // Delivery of a result frees the input side
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> s_tready)
    else $error("not ready after result delivery");

endmodule

bind tmr_byte_store_scrubber tbss_chk u_tbss_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/tbss_checker.sv
`timescale 1ns / 1ps
// Checker for the triple-redundant byte store: predicts each result and compares it.
module tbss_checker import tbss_pkg::*; #(
  parameter int STORE_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [OUT_W-1:0]   m_tdata,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_checked,
  output int                 diverged_bytes
);

  logic [BYTE_W-1:0] live_img     [STORE_BYTES];
  logic [BYTE_W-1:0] shadow_b_img [STORE_BYTES];
  logic [BYTE_W-1:0] shadow_c_img [STORE_BYTES];
  logic [CNT_W-1:0]  fixed_cnt;
  logic [CNT_W-1:0]  lost_cnt;
  logic [CNT_W-1:0]  scrub_cnt;
  logic [LEN_W-1:0]  prot_len;
  result_t           pending_results [$];
  int                fail_cnt;
  int                checked_cnt;
  int                diverged_cnt;

  // Apply one item to the shadow image of the store and return its result.
  function automatic result_t predict_item(input logic [IN_W-1:0] word);
    logic [FUNC_W-1:0] fn;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] d;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    logic [BYTE_W-1:0] z;
    int                n;
    result_t           res;
    fn  = word[2:0];
    a   = word[12:3];
    d   = word[20:13];
    sel = word[22:21];
    res = '0;
    n   = (prot_len > STORE_BYTES) ? STORE_BYTES : int'(prot_len);
    case (fn)
      FN_READ: begin
        if (a < STORE_BYTES) begin
          case (sel)
            SEL_LIVE: res.rdata = live_img[a];
            SEL_B:    res.rdata = shadow_b_img[a];
            SEL_C:    res.rdata = shadow_c_img[a];
            default:  res.rdata = '0;
          endcase
        end
      end
      FN_WRITE: begin
        if (a < STORE_BYTES) begin
          case (sel)
            SEL_LIVE: live_img[a] = d;
            SEL_B:    shadow_b_img[a] = d;
            SEL_C:    shadow_c_img[a] = d;
            default:  ;
          endcase
        end
      end
      FN_COMMIT: begin
        for (int i = 0; i < n; i++) begin
          shadow_b_img[i] = live_img[i];
          shadow_c_img[i] = live_img[i];
        end
      end
      FN_SCRUB: begin
        for (int i = 0; i < n; i++) begin
          x = live_img[i];
          y = shadow_b_img[i];
          z = shadow_c_img[i];
          if (!(x == y && y == z)) begin
            res.divergent_count = res.divergent_count + 1'b1;
            if (x == y) begin
              shadow_c_img[i] = x;
              fixed_cnt = fixed_cnt + 1'b1;
            end else if (x == z) begin
              shadow_b_img[i] = x;
              fixed_cnt = fixed_cnt + 1'b1;
            end else if (y == z) begin
              live_img[i] = y;
              fixed_cnt = fixed_cnt + 1'b1;
            end else begin
              // no majority: shadow B wins
              live_img[i] = y;
              shadow_c_img[i] = y;
              lost_cnt = lost_cnt + 1'b1;
            end
          end
        end
        scrub_cnt = scrub_cnt + 1'b1;
      end
      FN_CLEAR: begin
        fixed_cnt = '0;
        lost_cnt  = '0;
        scrub_cnt = '0;
      end
      default: ;
    endcase
    res.corrected_total     = fixed_cnt;
    res.uncorrectable_total = lost_cnt;
    res.scrub_runs_total    = scrub_cnt;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        live_img[i]     = '0;
        shadow_b_img[i] = '0;
        shadow_c_img[i] = '0;
      end
      fixed_cnt    = '0;
      lost_cnt     = '0;
      scrub_cnt    = '0;
      prot_len     = '0;
      fail_cnt     = 0;
      checked_cnt  = 0;
      diverged_cnt = 0;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_PROTECTED)
        prot_len = pwdata[LEN_W-1:0];
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result item with no expectation pending", $realtime);
        end else begin
          want = pending_results.pop_front();
          check_field("rdata", CNT_W'(want.rdata), CNT_W'(got.rdata));
          check_field("divergent_count", CNT_W'(want.divergent_count),
                      CNT_W'(got.divergent_count));
          check_field("corrected_total", want.corrected_total, got.corrected_total);
          check_field("uncorrectable_total", want.uncorrectable_total,
                      got.uncorrectable_total);
          check_field("scrub_runs_total", want.scrub_runs_total, got.scrub_runs_total);
          checked_cnt++;
          diverged_cnt += int'(got.divergent_count);
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_item(s_tdata));
    end
    mismatches      <= fail_cnt;
    outstanding     <= pending_results.size();
    results_checked <= checked_cnt;
    diverged_bytes  <= diverged_cnt;
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the triple-redundant byte store: stimulus, handshake pressure, verdict.
module tb;
  import tbss_pkg::*;

  localparam int STORE_BYTES    = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 140;

  // Idle rate of the sender, stall rate of the receiver and protected length per phase
  localparam int PHASE_SRC  [4] = '{0, 87, 0, 33};
  localparam int PHASE_SINK [4] = '{0, 0, 87, 33};
  localparam int PHASE_LEN  [4] = '{48, 1024, 17, 64};

  // Function codes the block does not use, and the copy select that names no copy
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
  localparam logic [SEL_W-1:0]  SEL_NONE    = 2'd3;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // s_tdata: func[2:0], addr[12:3], wdata[20:13], copy_select[22:21], zero[23]
  logic [IN_W-1:0]    s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // m_tdata: rdata[7:0], divergent_count[18:8], corrected_total[50:19],
  //          uncorrectable_total[82:51], scrub_runs_total[114:83], zero[119:115]
  logic [OUT_W-1:0]   m_tdata;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches;
  int outstanding;
  int results_checked;
  int diverged_bytes;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int region         = 1;
  int sent           = 0;
  int quiet_cycles   = 0;

  always #6 clk = ~clk;

  tmr_byte_store_scrubber #(.STORE_BYTES(STORE_BYTES)) i_dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tbss_checker #(.STORE_BYTES(STORE_BYTES)) i_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding, .results_checked, .diverged_bytes
  );

  // Stall the result side at the rate the current phase asks for.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: give up once nothing has moved on either side for too long.
  // The clearing pass after reset and a full-store walk both fit well inside.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item; idle first at the phase rate, then hold it until taken.
  task automatic push_item(input logic [FUNC_W-1:0] fn, input int a,
                           input logic [BYTE_W-1:0] d, input logic [SEL_W-1:0] sel);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, sel, d, ADDR_W'(a), fn};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Drop valid and hold off until every expected result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write protected_bytes over APB once the block is idle.
  task automatic set_protected(input int len);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PROTECTED, 2'b00};
    pwdata  <= 32'(len);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    region  = (len > STORE_BYTES) ? STORE_BYTES : ((len < 1) ? 1 : len);
  endtask

  function automatic int region_addr();
    return $urandom_range(region - 1, 0);
  endfunction

  function automatic logic [SEL_W-1:0] pick_sel();
    return SEL_W'($urandom_range(3));
  endfunction

  // One fault-injection round: fill, maybe commit, corrupt copies, scrub, maybe read back, rarely clear totals.
  task automatic scrub_round();
    int n;
    n = $urandom_range(3);
    repeat (n) push_item(FN_WRITE, region_addr(), BYTE_W'($urandom), SEL_LIVE);
    if ($urandom_range(3) != 0)
      push_item(FN_COMMIT, $urandom_range(1023), BYTE_W'($urandom), pick_sel());
    n = $urandom_range(4, 1);
    repeat (n) push_item(FN_WRITE, region_addr(), BYTE_W'($urandom),
                         SEL_W'($urandom_range(2)));
    push_item(FN_SCRUB, $urandom_range(1023), BYTE_W'($urandom), pick_sel());
    n = $urandom_range(2);
    repeat (n) push_item(FN_READ, region_addr(), BYTE_W'($urandom),
                         SEL_W'($urandom_range(3)));
    if ($urandom_range(11) == 0)
      push_item(FN_CLEAR, $urandom_range(1023), BYTE_W'($urandom), pick_sel());
  endtask

  // Anything the fields allow, unused function codes included.
  task automatic noise_item();
    push_item(FUNC_W'($urandom_range(7)), $urandom_range(1023), BYTE_W'($urandom),
              SEL_W'($urandom_range(3)));
  endtask

  initial begin
    int rounds;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: one byte per voting outcome over a short protected length.
    set_protected(8);
    push_item(FN_WRITE, 0, 8'hFF, SEL_LIVE);
    push_item(FN_WRITE, 1, 8'h3C, SEL_LIVE);
    push_item(FN_WRITE, 2, 8'h5A, SEL_LIVE);
    push_item(FN_WRITE, 3, 8'h81, SEL_LIVE);
    push_item(FN_COMMIT, 0, 8'h00, SEL_LIVE);
    push_item(FN_WRITE, 1, 8'h11, SEL_B);     // live agrees with C
    push_item(FN_WRITE, 0, 8'h00, SEL_C);     // live agrees with B
    push_item(FN_WRITE, 2, 8'h03, SEL_LIVE);  // shadows agree, live is off
    push_item(FN_WRITE, 3, 8'h07, SEL_B);     // three distinct bytes
    push_item(FN_WRITE, 3, 8'h09, SEL_C);
    push_item(FN_SCRUB, 0, 8'h00, SEL_LIVE);
    push_item(FN_READ, 3, 8'h00, SEL_LIVE);
    push_item(FN_READ, 3, 8'h00, SEL_B);
    push_item(FN_READ, 3, 8'h00, SEL_C);
    // Select three names no copy: read gives zero, write is dropped
    push_item(FN_READ, 0, 8'h00, SEL_NONE);
    push_item(FN_WRITE, 0, 8'hEE, SEL_NONE);
    push_item(FN_READ, 0, 8'h00, SEL_LIVE);
    push_item(FN_WRITE, 1023, 8'hFF, SEL_LIVE);
    push_item(FN_READ, 1023, 8'hFF, SEL_LIVE);
    push_item(FN_SPARE_LO, 1023, 8'hFF, SEL_NONE);
    push_item(FN_SPARE_HI, 0, 8'h00, SEL_LIVE);
    push_item(FN_CLEAR, 0, 8'h00, SEL_LIVE);
    push_item(FN_SCRUB, 0, 8'h00, SEL_LIVE);
    // A scrub over nothing still counts as a run
    set_protected(0);
    push_item(FN_SCRUB, 0, 8'h00, SEL_LIVE);
    // Oversized length saturates to the whole store
    set_protected(2047);
    push_item(FN_WRITE, 1023, 8'h01, SEL_C);
    push_item(FN_SCRUB, 0, 8'h00, SEL_LIVE);

    // Random phases: mostly fault-injection rounds, some noise, and an
    // occasional full drain so the sender sits idle with nothing in flight.
    for (int p = 0; p < 4; p++) begin
      set_protected(PHASE_LEN[p]);
      src_idle_pct   = PHASE_SRC[p];
      sink_stall_pct = PHASE_SINK[p];
      rounds = 0;
      sent   = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8)
          scrub_round();
        else
          noise_item();
        rounds++;
        if (rounds % 9 == 0)
          drain();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("summary: %0d results checked across four handshake phases,", results_checked);
    $display("summary: protected lengths 0 to 2047, %0d divergent bytes voted", diverged_bytes);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
